// File: rtl/core/mesc_pkg.sv
// Shared constants, types and step functions of the edge silhouette and crease classifier.
package mesc_pkg;

   localparam int INDEX_BITS = 24;
   localparam int COORD_W    = 21;
   localparam int VEC_W      = 3 * COORD_W;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQT_W      = 2 * DIFF_W - 1;
   localparam int SQ_W       = SQT_W + 1;
   localparam int NDT_W      = COORD_W + DIFF_W;
   localparam int ND_W       = NDT_W + 2;
   localparam int NDA_W      = ND_W - 1;
   localparam int FPT_W      = 2 * COORD_W;
   localparam int DOT_W      = FPT_W + 2;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int LEN_W      = SQRT_STEPS + 1;
   localparam int Q_W        = LEN_W;
   localparam int CMP_W      = LEN_W + Q_W;
   localparam int WQ_W       = 17;
   localparam int WD_W       = Q_W + 1;
   localparam int WR_W       = WD_W + WQ_W - 1;
   localparam int WCMP_W     = WR_W + 1;
   localparam int LEVEL_W    = 17;
   localparam int LEVEL_ONE  = 65536;
   localparam int CREASE_SH  = 22;
   localparam int PIPE_LAST  = 4 + SQRT_STEPS + Q_W + WQ_W;
   localparam int REQ_DATA_W = 432;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_X        = 3'd0,
      CSR_VIEW_Y        = 3'd1,
      CSR_VIEW_Z        = 3'd2,
      CSR_CREASE_ENABLE = 3'd3,
      CSR_CREASE_LEVEL  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic is_boundary;
      logic is_duplicate;
      logic is_crease;
   } flags_type;

   typedef struct packed {
      logic [SQ_W-1:0]  x;
      logic [SQ_W-1:0]  res;
      logic [NDA_W-1:0] nda;
      logic             neg;
   } sqrt_lane_type;

   typedef struct packed {
      logic [NDA_W-1:0] r;
      logic [Q_W-1:0]   q;
      logic [LEN_W-1:0] len;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      logic [WR_W-1:0] r;
      logic [WQ_W-1:0] q;
      logic [WD_W-1:0] dd;
      logic            sil;
   } wdiv_type;

   function automatic sqrt_lane_type sqrt_step(sqrt_lane_type s, int k);
      logic [SQ_W-1:0] bitv;
      logic [SQ_W:0]   trial;
      sqrt_lane_type   o;
      o     = s;
      bitv  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = {1'b0, s.res} + {1'b0, bitv};
      if ({1'b0, s.x} >= trial) begin
         o.x   = s.x - trial[SQ_W-1:0];
         o.res = (s.res >> 1) + bitv;
      end else begin
         o.res = s.res >> 1;
      end
      return o;
   endfunction

   function automatic div_lane_type div_step(div_lane_type s, int k);
      logic [CMP_W-1:0] dsh;
      div_lane_type     o;
      o   = s;
      dsh = CMP_W'(s.len) << (Q_W - 1 - k);
      if (CMP_W'(s.r) >= dsh) begin
         o.r = s.r - dsh[NDA_W-1:0];
         o.q = s.q | (Q_W'(1) << (Q_W - 1 - k));
      end
      return o;
   endfunction

   function automatic wdiv_type wdiv_step(wdiv_type s, int k);
      logic [WCMP_W-1:0] dsh;
      wdiv_type          o;
      o   = s;
      dsh = WCMP_W'(s.dd) << (WQ_W - 1 - k);
      if (WCMP_W'(s.r) >= dsh) begin
         o.r = s.r - dsh[WR_W-1:0];
         o.q = s.q | (WQ_W'(1) << (WQ_W - 1 - k));
      end
      return o;
   endfunction

endpackage

// File: rtl/core/mesh_edge_silhouette_crease_classifier_top.sv
// Top level of the edge silhouette and crease classifier pipeline.
//
// One half-edge word enters on the req_ channel and one classification word
// leaves on the rsp_ channel for every edge, in order. A word is taken when
// tvalid and tready are both high. The csr_ channel writes the viewpoint and
// the crease settings; it is always ready and should only be used while no
// edge is in flight.
// The pipeline has 67 register stages and an output register. One edge is
// taken every cycle while the skid register is empty:
// the square root unit retires one result bit per stage over 22 stages, the
// facing division one quotient bit per stage over 23 stages and the weight
// division one bit per stage over 17 stages.
// When the receiver stalls, results collect in the output register and a
// one-word skid register; once the skid register is full the whole pipeline
// holds and req_tready falls. Nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module mesh_edge_silhouette_crease_classifier_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_position, end_position, start_normal, end_normal, face_normal,
   // twin_face_normal, face_index, twin_face_index, zero fill
   input  logic [mesc_pkg::REQ_DATA_W-1:0]        req_tdata,
   // has_twin
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // silhouette_weight, zero fill
   output logic [mesc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // is_boundary, is_duplicate, is_silhouette, is_crease
   output logic [3:0]                            rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mesc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mesc_pkg::COORD_W-1:0]           csr_data
);

   localparam int LAST = mesc_pkg::PIPE_LAST;
   localparam int CW   = mesc_pkg::COORD_W;

   typedef struct packed {
      logic [3:0]                  kind;
      logic [mesc_pkg::WQ_W-1:0]   weight;
   } result_type;

   logic signed [CW-1:0]              view_ff [3];
   logic                              crease_en_ff;
   logic [mesc_pkg::LEVEL_W-1:0]      crease_level_ff;

   logic [LAST:0]                     vld_ff;
   mesc_pkg::flags_type               flg_ff [LAST+1];
   mesc_pkg::flags_type               flg_in;
   logic                              adv;

   logic signed [mesc_pkg::DIFF_W-1:0] d_ff  [2][3];
   logic signed [CW-1:0]               n_ff  [2][3];
   logic signed [CW-1:0]               m_ff  [2][3];
   logic [mesc_pkg::SQT_W-1:0]         sqt_ff [2][3];
   logic signed [mesc_pkg::NDT_W-1:0]  ndt_ff [2][3];
   logic signed [mesc_pkg::FPT_W-1:0]  fpt_ff [3];

   mesc_pkg::sqrt_lane_type sr_ff [mesc_pkg::SQRT_STEPS+1][2];
   mesc_pkg::div_lane_type  dv_ff [mesc_pkg::Q_W+1][2];
   mesc_pkg::wdiv_type      wt_ff [mesc_pkg::WQ_W+1];

   logic [mesc_pkg::SQ_W-1:0]          sq_sum    [2];
   logic signed [mesc_pkg::ND_W-1:0]   nd_sum    [2];
   logic [mesc_pkg::NDA_W-1:0]         nd_abs    [2];
   logic signed [mesc_pkg::DOT_W-1:0]  dot_sum;
   logic [mesc_pkg::DOT_W-1:0]         dot_abs;
   logic [mesc_pkg::DOT_W-1:0]         thr;
   logic                               crease_hit;
   logic [mesc_pkg::Q_W-1:0]           fa   [2];
   logic                               fpos [2];

   result_type                         pipe_res;
   result_type                         out_ff;
   result_type                         skid_ff;
   logic                               out_vld_ff;
   logic                               skid_vld_ff;
   logic                               take;
   logic                               push;
   logic                               sil_fin;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff[0]      <= '0;
         view_ff[1]      <= '0;
         view_ff[2]      <= '0;
         crease_en_ff    <= 1'b0;
         crease_level_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            mesc_pkg::CSR_VIEW_X:        view_ff[0] <= csr_data;
            mesc_pkg::CSR_VIEW_Y:        view_ff[1] <= csr_data;
            mesc_pkg::CSR_VIEW_Z:        view_ff[2] <= csr_data;
            mesc_pkg::CSR_CREASE_ENABLE: crease_en_ff <= csr_data[0];
            mesc_pkg::CSR_CREASE_LEVEL:  crease_level_ff <= csr_data[mesc_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   always_comb begin
      flg_in.is_boundary  = !req_tuser;
      flg_in.is_duplicate = req_tuser &&
         (req_tdata[402 +: mesc_pkg::INDEX_BITS] < req_tdata[378 +: mesc_pkg::INDEX_BITS]);
      flg_in.is_crease    = crease_en_ff && !flg_in.is_boundary && !flg_in.is_duplicate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_tvalid};
      end
   end

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         sq_sum[e] = mesc_pkg::SQ_W'(sqt_ff[e][0]) + mesc_pkg::SQ_W'(sqt_ff[e][1])
                   + mesc_pkg::SQ_W'(sqt_ff[e][2]);
         nd_sum[e] = mesc_pkg::ND_W'(ndt_ff[e][0]) + mesc_pkg::ND_W'(ndt_ff[e][1])
                   + mesc_pkg::ND_W'(ndt_ff[e][2]);
         nd_abs[e] = nd_sum[e][mesc_pkg::ND_W-1] ? mesc_pkg::NDA_W'(-nd_sum[e])
                                                 : mesc_pkg::NDA_W'(nd_sum[e]);
      end
      dot_sum = mesc_pkg::DOT_W'(fpt_ff[0]) + mesc_pkg::DOT_W'(fpt_ff[1])
              + mesc_pkg::DOT_W'(fpt_ff[2]);
      dot_abs = dot_sum[mesc_pkg::DOT_W-1] ? mesc_pkg::DOT_W'(-dot_sum)
                                           : mesc_pkg::DOT_W'(dot_sum);
      thr = mesc_pkg::DOT_W'(mesc_pkg::LEVEL_ONE - 32'(crease_level_ff)) << mesc_pkg::CREASE_SH;
      crease_hit = (32'(crease_level_ff) <= mesc_pkg::LEVEL_ONE) && (dot_abs < thr);
      for (int e = 0; e < 2; e++) begin
         fa[e]   = (dv_ff[mesc_pkg::Q_W][e].len == '0) ? '0 : dv_ff[mesc_pkg::Q_W][e].q;
         fpos[e] = !dv_ff[mesc_pkg::Q_W][e].neg && (fa[e] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flg_ff[0] <= flg_in;
         for (int s = 1; s <= LAST; s++) begin
            if (s == 2) begin
               flg_ff[s] <= {flg_ff[1].is_boundary, flg_ff[1].is_duplicate,
                             flg_ff[1].is_crease && crease_hit};
            end else begin
               flg_ff[s] <= flg_ff[s-1];
            end
         end

         for (int k = 0; k < 3; k++) begin
            d_ff[0][k] <= mesc_pkg::DIFF_W'($signed(req_tdata[k*CW +: CW]))
                          - mesc_pkg::DIFF_W'(view_ff[k]);
            d_ff[1][k] <= mesc_pkg::DIFF_W'($signed(req_tdata[mesc_pkg::VEC_W + k*CW +: CW]))
                          - mesc_pkg::DIFF_W'(view_ff[k]);
            n_ff[0][k] <= $signed(req_tdata[2*mesc_pkg::VEC_W + k*CW +: CW]);
            n_ff[1][k] <= $signed(req_tdata[3*mesc_pkg::VEC_W + k*CW +: CW]);
            m_ff[0][k] <= $signed(req_tdata[4*mesc_pkg::VEC_W + k*CW +: CW]);
            m_ff[1][k] <= $signed(req_tdata[5*mesc_pkg::VEC_W + k*CW +: CW]);
         end

         for (int e = 0; e < 2; e++) begin
            for (int k = 0; k < 3; k++) begin
               sqt_ff[e][k] <= mesc_pkg::SQT_W'(d_ff[e][k] * d_ff[e][k]);
               ndt_ff[e][k] <= mesc_pkg::NDT_W'(n_ff[e][k] * d_ff[e][k]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            fpt_ff[k] <= mesc_pkg::FPT_W'(m_ff[0][k] * m_ff[1][k]);
         end

         for (int e = 0; e < 2; e++) begin
            sr_ff[0][e].x   <= sq_sum[e];
            sr_ff[0][e].res <= '0;
            sr_ff[0][e].nda <= nd_abs[e];
            sr_ff[0][e].neg <= nd_sum[e][mesc_pkg::ND_W-1];
            for (int k = 1; k <= mesc_pkg::SQRT_STEPS; k++) begin
               sr_ff[k][e] <= mesc_pkg::sqrt_step(sr_ff[k-1][e], k-1);
            end
            dv_ff[0][e].r   <= sr_ff[mesc_pkg::SQRT_STEPS][e].nda;
            dv_ff[0][e].q   <= '0;
            dv_ff[0][e].len <= sr_ff[mesc_pkg::SQRT_STEPS][e].res[mesc_pkg::LEN_W-1:0];
            dv_ff[0][e].neg <= sr_ff[mesc_pkg::SQRT_STEPS][e].neg;
            for (int k = 1; k <= mesc_pkg::Q_W; k++) begin
               dv_ff[k][e] <= mesc_pkg::div_step(dv_ff[k-1][e], k-1);
            end
         end

         wt_ff[0].r   <= mesc_pkg::WR_W'(fa[1]) << (mesc_pkg::WQ_W - 1);
         wt_ff[0].q   <= '0;
         wt_ff[0].dd  <= mesc_pkg::WD_W'(fa[0]) + mesc_pkg::WD_W'(fa[1]);
         wt_ff[0].sil <= fpos[0] ^ fpos[1];
         for (int k = 1; k <= mesc_pkg::WQ_W; k++) begin
            wt_ff[k] <= mesc_pkg::wdiv_step(wt_ff[k-1], k-1);
         end
      end
   end

   always_comb begin
      sil_fin = wt_ff[mesc_pkg::WQ_W].sil && !flg_ff[LAST].is_boundary
                && !flg_ff[LAST].is_duplicate;
      pipe_res.kind   = {flg_ff[LAST].is_crease, sil_fin,
                         flg_ff[LAST].is_duplicate, flg_ff[LAST].is_boundary};
      pipe_res.weight = sil_fin ? wt_ff[mesc_pkg::WQ_W].q : '0;
   end

   assign take = out_vld_ff && rsp_tready;
   assign push = adv && vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            out_ff      <= skid_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || take) begin
            out_ff     <= pipe_res;
            out_vld_ff <= 1'b1;
         end else begin
            skid_ff     <= pipe_res;
            skid_vld_ff <= 1'b1;
         end
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = mesc_pkg::RSP_DATA_W'(out_ff.weight);

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid word held without output word");
   a_boundary_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[3:1] == 3'b000 && rsp_tdata == '0))
      else $error("boundary edge carries other results");
   a_weight_needs_sil: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[2]) |-> (rsp_tdata == '0))
      else $error("weight without silhouette");
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata) <= mesc_pkg::LEVEL_ONE))
      else $error("weight above one");
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready && push) |=> skid_vld_ff)
      else $error("stalled result not caught by skid register");
`endif

endmodule
